// ===== src/wlp_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted lottery picker package
// Shared constants, codes and types of the weighted lottery picker.
// ----------------------------------------------------------------------------
`default_nettype none

package wlp_pkg;

  // Table size and field widths.
  localparam int ENTRIES   = 256;
  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int DUR_W     = 32;
  localparam int RND_W     = 31;
  localparam int WGT_W     = 22;
  localparam int TOT_W     = 48;
  localparam int RUN_W     = 16;
  localparam int STAT_W    = 2;

  // Sum of all weights fits in SUM_W bits: 256 * (2^22 - 1) < 2^30.
  localparam int SUM_W     = 30;
  // Record dividend is the total with the 1/1024 second bits dropped.
  localparam int FRAC_W    = 10;
  localparam int QUO_W     = TOT_W - FRAC_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic {
    OP_PICK   = 1'b0,
    OP_RECORD = 1'b1
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_REC_RD,
    ST_REC_CALC,
    ST_REC_WR,
    ST_SEL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [TOT_W-1:0] total;
    logic [RUN_W-1:0] runs;
    logic [WGT_W-1:0] weight;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_index;
    logic             was_unstudied;
    logic [WGT_W-1:0] new_weight;
    status_e          status;
  } result_t;

endpackage

`default_nettype wire

// ===== src/wlp_chan_if.sv =====
// ----------------------------------------------------------------------------
// Weighted lottery picker channels
// Valid/ready channels for request words, result words and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one pick or record request per word.
interface wlp_req_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [wlp_pkg::IDX_W-1:0] entry_index;
  logic [wlp_pkg::DUR_W-1:0] duration;
  logic [wlp_pkg::RND_W-1:0] random_value;

  modport source (output valid, output opcode, output entry_index, output duration,
                  output random_value, input ready);
  modport sink   (input valid, input opcode, input entry_index, input duration,
                  input random_value, output ready);
endinterface

// Result channel: one word per request.
interface wlp_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [wlp_pkg::IDX_W-1:0]  chosen_index;
  logic                       was_unstudied;
  logic [wlp_pkg::WGT_W-1:0]  new_weight;
  logic [wlp_pkg::STAT_W-1:0] status;

  modport source (output valid, output chosen_index, output was_unstudied,
                  output new_weight, output status, input ready);
  modport sink   (input valid, input chosen_index, input was_unstudied,
                  input new_weight, input status, output ready);
endinterface

// Configuration channel: writes the entry count register.
interface wlp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [wlp_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, output entry_count, input ready);
  modport sink   (input valid, input entry_count, output ready);
endinterface

`default_nettype wire

// ===== src/weighted_lottery_picker.sv =====
// ----------------------------------------------------------------------------
// Weighted lottery picker
// Roulette-wheel selection over a table of entries, with entries that were
// never studied drawn first.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_chan writes the number of entries in use (clamped to 256); it is
//   always ready and should be written while no request is in flight.
//   req_chan takes one word at a time. A record word adds a duration to one
//   entry and returns the new weight; a pick word returns a chosen entry.
//   rsp_chan returns exactly one word per request, in order.
// Timing:
//   A record reads the table, forms the mean with the 38-step restoring
//   divider and writes the entry back before its result word is valid. A pick
//   makes one pass over the table memory to total the weights, uses the shared
//   divider for the modulo, and makes a second pass to select.
//   Out-of-range records and picks on an empty table go straight to the
//   response state. req_chan is ready only while the block is idle, so the
//   next request can be taken in the same cycle as the result word appears,
//   at the earliest.
// Reset and stall:
//   Reset clears the control registers and marks every table entry as
//   unwritten, so all entries read as zero; no clearing pass is needed. A
//   finished word sits in the output register; a new request is taken
//   meanwhile, and its result waits inside until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_lottery_picker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wlp_cfg_if.sink   cfg_chan,
  wlp_req_if.sink   req_chan,
  wlp_rsp_if.source rsp_chan
);
  import wlp_pkg::*;

  // Control and item registers.
  state_e            state_q, state_d;
  opcode_e           op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [DUR_W-1:0]  dur_q, dur_d;
  logic [RND_W-1:0]  rnd_q, rnd_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  cfg_q;

  // Scan registers.
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  zeros_q, zeros_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]  seen_q, seen_d;
  logic              unstud_q, unstud_d;

  // Shared divider registers.
  logic [SUM_W-1:0]  div_rem_q, div_rem_d;
  logic [QUO_W-1:0]  div_quo_q, div_quo_d;
  logic [SUM_W-1:0]  div_den_q, div_den_d;
  logic [STEP_W-1:0] div_cnt_q, div_cnt_d;

  // Record write-back and result registers.
  logic [TOT_W-1:0]  tot_q, tot_d;
  logic [RUN_W-1:0]  runs_q, runs_d;
  result_t           res_q, res_d;
  result_t           out_q;
  logic              out_valid_q;

  // Table memory with one valid bit per entry.
  entry_t            mem_q [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  entry_t            mem_rd_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  entry_t            mem_wd;

  // Combinational helpers.
  logic [CNT_W-1:0]  n_w;
  logic              in_fire;
  logic              out_free;
  entry_t            rd_ent;
  logic [WGT_W-1:0]  rd_w;
  logic              scan_more;
  logic              scan_end;
  logic [SUM_W-1:0]  run_nx;
  logic              sel_hit;
  logic [SUM_W:0]    div_trial;
  logic              div_ge;
  logic [SUM_W:0]    div_diff;
  logic [TOT_W:0]    tot_sum;
  logic [TOT_W-1:0]  tot_new;
  logic [RUN_W-1:0]  runs_new;
  logic [WGT_W-1:0]  w_sat;

  // Entries in use, clamped to the table size.
  assign n_w = (cfg_q > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : cfg_q;

  // Handshakes.
  assign req_chan.ready = (state_q == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = req_chan.valid && req_chan.ready;
  assign out_free       = !out_valid_q || rsp_chan.ready;

  assign rsp_chan.valid         = out_valid_q;
  assign rsp_chan.chosen_index  = out_q.chosen_index;
  assign rsp_chan.was_unstudied = out_q.was_unstudied;
  assign rsp_chan.new_weight    = out_q.new_weight;
  assign rsp_chan.status        = out_q.status;

  // Read data; an unwritten entry reads as zero.
  assign rd_ent = rd_vld_q ? mem_rd_q : '0;
  assign rd_w   = rd_ent.weight;

  // Scan progress and selection test.
  assign scan_more = (scan_q < n_q);
  assign scan_end  = !scan_more && !pend_q;
  assign run_nx    = run_q + SUM_W'(rd_w);
  assign sel_hit   = pend_q && (unstud_q ? ((rd_w == '0) && (seen_q == div_rem_q[CNT_W-1:0]))
                                         : (run_nx > div_rem_q));

  // One restoring division step.
  assign div_trial = {div_rem_q, div_quo_q[QUO_W-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den_q});
  assign div_diff  = div_trial - {1'b0, div_den_q};

  // Saturating accumulation for a record.
  assign tot_sum  = {1'b0, rd_ent.total} + (TOT_W+1)'(dur_q);
  assign tot_new  = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
  assign runs_new = (rd_ent.runs == '1) ? rd_ent.runs : rd_ent.runs + 1'b1;
  assign w_sat    = (|div_quo_q[QUO_W-1:WGT_W]) ? '1 : div_quo_q[WGT_W-1:0];

  // Memory port control.
  assign rd_addr = (state_q == ST_REC_RD) ? idx_q : scan_q[IDX_W-1:0];
  assign mem_we  = (state_q == ST_REC_WR);
  assign mem_wd  = '{total: tot_q, runs: runs_q, weight: w_sat};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (req_chan.opcode == OP_RECORD) begin
            state_d = ({1'b0, req_chan.entry_index} >= n_w) ? ST_RESP : ST_REC_RD;
          end else begin
            state_d = (n_w == '0) ? ST_RESP : ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (scan_end) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == STEP_W'(1)) state_d = (op_q == OP_RECORD) ? ST_REC_WR : ST_SEL;
      end
      ST_REC_RD:   state_d = ST_REC_CALC;
      ST_REC_CALC: state_d = ST_DIV;
      ST_REC_WR:   state_d = ST_RESP;
      ST_SEL: begin
        if (sel_hit || scan_end) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    op_d      = op_q;
    idx_d     = idx_q;
    dur_d     = dur_q;
    rnd_d     = rnd_q;
    n_d       = n_q;
    scan_d    = scan_q;
    pend_d    = pend_q;
    rd_idx_d  = rd_idx_q;
    zeros_d   = zeros_q;
    sum_d     = sum_q;
    run_d     = run_q;
    seen_d    = seen_q;
    unstud_d  = unstud_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_den_d = div_den_q;
    div_cnt_d = div_cnt_q;
    tot_d     = tot_q;
    runs_d    = runs_q;
    res_d     = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d    = opcode_e'(req_chan.opcode);
          idx_d   = req_chan.entry_index;
          dur_d   = req_chan.duration;
          rnd_d   = req_chan.random_value;
          n_d     = n_w;
          scan_d  = '0;
          pend_d  = 1'b0;
          zeros_d = '0;
          sum_d   = '0;
          // Requests that answer at once.
          if (req_chan.opcode == OP_RECORD) begin
            res_d = '{chosen_index: req_chan.entry_index, was_unstudied: 1'b0,
                      new_weight: '0, status: STAT_RANGE};
          end else begin
            res_d = '{chosen_index: '0, was_unstudied: 1'b0,
                      new_weight: '0, status: STAT_EMPTY};
          end
        end
      end
      ST_SUM: begin
        // Issue the next read and fold in the previous one.
        if (scan_more) begin
          scan_d   = scan_q + 1'b1;
          pend_d   = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          zeros_d = zeros_q + CNT_W'(rd_w == '0);
          sum_d   = sum_q + SUM_W'(rd_w);
        end
        // Set up the modulo by the zero count or by the weight total.
        if (scan_end) begin
          unstud_d  = (zeros_q != '0);
          div_rem_d = '0;
          div_quo_d = QUO_W'(rnd_q);
          div_den_d = (zeros_q != '0) ? SUM_W'(zeros_q) : sum_q;
          div_cnt_d = STEP_W'(DIV_STEPS);
        end
      end
      ST_DIV: begin
        div_rem_d = div_ge ? div_diff[SUM_W-1:0] : div_trial[SUM_W-1:0];
        div_quo_d = {div_quo_q[QUO_W-2:0], div_ge};
        div_cnt_d = div_cnt_q - 1'b1;
        // Prepare the selection pass.
        scan_d    = '0;
        pend_d    = 1'b0;
        run_d     = '0;
        seen_d    = '0;
      end
      ST_REC_RD: begin
      end
      ST_REC_CALC: begin
        // Mean in seconds: (total / 1024) / runs.
        tot_d     = tot_new;
        runs_d    = runs_new;
        div_rem_d = '0;
        div_quo_d = tot_new[TOT_W-1:FRAC_W];
        div_den_d = SUM_W'(runs_new);
        div_cnt_d = STEP_W'(DIV_STEPS);
      end
      ST_REC_WR: begin
        res_d = '{chosen_index: idx_q, was_unstudied: 1'b0,
                  new_weight: w_sat, status: STAT_OK};
      end
      ST_SEL: begin
        if (scan_more) begin
          scan_d   = scan_q + 1'b1;
          pend_d   = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (unstud_q) begin
            if (rd_w == '0) seen_d = seen_q + 1'b1;
          end else begin
            run_d = run_nx;
          end
        end
        if (sel_hit) begin
          res_d = '{chosen_index: rd_idx_q, was_unstudied: unstud_q,
                    new_weight: '0, status: STAT_OK};
        end else if (scan_end) begin
          res_d = '{chosen_index: unstud_q ? '0 : IDX_W'(n_q - 1'b1),
                    was_unstudied: unstud_q, new_weight: '0, status: STAT_OK};
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (cfg_chan.valid && cfg_chan.ready) cfg_q <= cfg_chan.entry_count;
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_chan.ready) begin
        out_valid_q <= 1'b0;
      end
      if (mem_we) vld_q[idx_q] <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    idx_q     <= idx_d;
    dur_q     <= dur_d;
    rnd_q     <= rnd_d;
    n_q       <= n_d;
    scan_q    <= scan_d;
    rd_idx_q  <= rd_idx_d;
    zeros_q   <= zeros_d;
    sum_q     <= sum_d;
    run_q     <= run_d;
    seen_q    <= seen_d;
    unstud_q  <= unstud_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_den_q <= div_den_d;
    div_cnt_q <= div_cnt_d;
    tot_q     <= tot_d;
    runs_q    <= runs_d;
    res_q     <= res_d;
    if (state_q == ST_RESP && out_free) out_q <= res_q;
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[idx_q] <= mem_wd;
    mem_rd_q <= mem_q[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
  end

  // A record only writes an entry that is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, idx_q} < n_q))
    else $error("record write outside the entries in use");

  // The drawn offset stays below the zero count or the weight total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEL) |-> (unstud_q ? (div_rem_q < SUM_W'(zeros_q)) : (div_rem_q < sum_q)))
    else $error("selection offset out of range");

  // The scan never runs past the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM || state_q == ST_SEL) |-> (scan_q <= CNT_W'(ENTRIES)))
    else $error("scan counter past the table");

  // A result word appears only after the response state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result word without a finished request");

endmodule

`default_nettype wire
